// ----- hdl/rwl_pkg.sv -----
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the region window locator.
// ----------------------------------------------------------------------------
package rwl_pkg;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 8;
    localparam int TAG_W   = 8;
    localparam int COORD_W = 32;
    localparam int Z_W     = 16;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

    // One table entry, 136 bits.
    typedef struct packed {
        logic [TAG_W-1:0]   region_tag;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [COORD_W-1:0] limit_x;
        logic [COORD_W-1:0] limit_y;
    } window_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;    // clear sweep writes one entry
        logic wr_en;     // write entry from the input item
        logic latch;     // capture the input item
        logic rd_start;  // first table read of an item
        logic rd_next;   // next table read of a scan
        logic out_load;  // load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            clr_last;
        logic            scan_done;
        logic            out_free;
    } sts_t;

endpackage

// ----- hdl/rwl_ctrl.sv -----
// ----------------------------------------------------------------------------
// rwl_ctrl
// Sequencer: clearing sweep, item decode, table scan and result hand-off.
// ----------------------------------------------------------------------------
module rwl_ctrl
    import rwl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CONV  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (sts.in_op)
                        OP_WRITE:
                        begin
                            cmd.wr_en = 1'b1;
                        end
                        OP_LOOKUP:
                        begin
                            cmd.latch    = 1'b1;
                            cmd.rd_start = 1'b1;
                            state_next   = S_SCAN;
                        end
                        OP_CONVERT:
                        begin
                            cmd.latch    = 1'b1;
                            cmd.rd_start = 1'b1;
                            state_next   = S_CONV;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // on a finished scan with a full output slot, hold everything
                if (sts.scan_done)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_CONV:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- hdl/rwl_dpath.sv -----
// ----------------------------------------------------------------------------
// rwl_dpath
// Window table memory, item registers, match logic and output register.
// ----------------------------------------------------------------------------
module rwl_dpath
    import rwl_pkg::*;
#(
    parameter int ENTRY_COUNT = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [OP_W-1:0]    in_op,
    input  logic [INDEX_W-1:0] in_entry_index,
    input  logic [TAG_W-1:0]   in_region_tag,
    input  logic [COORD_W-1:0] in_coord_x,
    input  logic [COORD_W-1:0] in_coord_y,
    input  logic [COORD_W-1:0] in_coord_z,
    input  logic [COORD_W-1:0] in_limit_x,
    input  logic [COORD_W-1:0] in_limit_y,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_found,
    output logic [INDEX_W-1:0] out_match_index,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [Z_W-1:0]     out_z
);

    localparam int AW         = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int SCAN_COUNT = (ENTRY_COUNT < 256) ? ENTRY_COUNT : 256;

    window_t mem [ENTRY_COUNT];

    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      cnt_reg;
    window_t            rd_data_reg;

    logic [OP_W-1:0]    op_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic               idx_ok_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic [Z_W-1:0]     cz_reg;

    logic               out_valid_reg;
    logic               found_reg;
    logic [INDEX_W-1:0] match_index_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [Z_W-1:0]     out_z_reg;

    logic               in_range;
    logic               we;
    logic [AW-1:0]      waddr;
    window_t            wdata;
    logic               rd_en;
    logic [AW-1:0]      raddr;
    logic               hit;
    logic               scan_last;
    logic [COORD_W-1:0] base_x_eff;
    logic [COORD_W-1:0] base_y_eff;
    logic               found_next;
    logic [INDEX_W-1:0] match_index_next;
    logic [COORD_W-1:0] out_x_next;
    logic [COORD_W-1:0] out_y_next;
    logic [Z_W-1:0]     out_z_next;

    assign in_range = (32'(in_entry_index) < ENTRY_COUNT);

    // Write port: clearing sweep or entry write
    always_comb
    begin
        we    = cmd.clr_en | (cmd.wr_en & in_range);
        waddr = cmd.clr_en ? clr_cnt_reg : AW'(in_entry_index);
        if (cmd.clr_en)
        begin
            wdata = '0;
        end
        else
        begin
            wdata.region_tag = in_region_tag;
            wdata.base_x     = in_coord_x;
            wdata.base_y     = in_coord_y;
            wdata.limit_x    = in_limit_x;
            wdata.limit_y    = in_limit_y;
        end
    end

    // Read port: a lookup starts at entry 0, a conversion reads its own entry
    assign rd_en = cmd.rd_start | cmd.rd_next;
    always_comb
    begin
        if (cmd.rd_start)
        begin
            raddr = (in_op == OP_CONVERT) ? AW'(in_entry_index) : '0;
        end
        else
        begin
            raddr = cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (rd_en)
            begin
                cnt_reg <= raddr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= in_op;
            idx_reg    <= in_entry_index;
            idx_ok_reg <= in_range;
            tag_reg    <= in_region_tag;
            cx_reg     <= in_coord_x;
            cy_reg     <= in_coord_y;
            cz_reg     <= in_coord_z[Z_W-1:0];
        end
    end

    // Entry under test is rd_data_reg, at index cnt_reg
    assign hit = (tag_reg != '0) && (rd_data_reg.region_tag == tag_reg) &&
                 (cx_reg >= rd_data_reg.base_x) && (cx_reg < rd_data_reg.limit_x) &&
                 (cy_reg >= rd_data_reg.base_y) && (cy_reg < rd_data_reg.limit_y);
    // region zero never matches, so it ends at once
    assign scan_last = (cnt_reg == AW'(SCAN_COUNT - 1)) || (tag_reg == '0);

    assign base_x_eff = idx_ok_reg ? rd_data_reg.base_x : '0;
    assign base_y_eff = idx_ok_reg ? rd_data_reg.base_y : '0;

    always_comb
    begin
        if (op_reg == OP_CONVERT)
        begin
            found_next       = 1'b1;
            match_index_next = idx_reg;
            out_x_next       = base_x_eff + {16'd0, cx_reg[15:0]};
            out_y_next       = base_y_eff + {16'd0, cy_reg[15:0]};
            out_z_next       = cz_reg;
        end
        else if (hit)
        begin
            found_next       = 1'b1;
            match_index_next = INDEX_W'(cnt_reg);
            out_x_next       = cx_reg - rd_data_reg.base_x;
            out_y_next       = cy_reg - rd_data_reg.base_y;
            out_z_next       = cz_reg;
        end
        else
        begin
            found_next       = 1'b0;
            match_index_next = '0;
            out_x_next       = '0;
            out_y_next       = '0;
            out_z_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg       <= found_next;
            match_index_reg <= match_index_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_z_reg       <= out_z_next;
        end
    end

    assign sts.in_op     = in_op;
    assign sts.clr_last  = (clr_cnt_reg == AW'(ENTRY_COUNT - 1));
    assign sts.scan_done = hit | scan_last;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_found       = found_reg;
    assign out_match_index = match_index_reg;
    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;
    assign out_z           = out_z_reg;

endmodule

// ----- hdl/region_window_locator_unit.sv -----
// ----------------------------------------------------------------------------
// region_window_locator_unit
// Table of rectangular windows with region lookup and coordinate conversion.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the table clear, one entry per cycle, and
// takes no item until the sweep is done. A write (op 0) gives no result. A
// lookup (op 1) walks the entries of the single table read port one per cycle
// in ascending index, over at most min(ENTRY_COUNT, 256) entries, and stops at
// the first hit; a lookup of region zero stops at entry 0 with no match. A
// conversion (op 2) reads its own entry and then waits for a free output slot.
// One item is in work at a time; the result sits in an output register so the
// next item can be taken while it waits to be read.
// ----------------------------------------------------------------------------
module region_window_locator_unit
    import rwl_pkg::*;
#(
    parameter int ENTRY_COUNT = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, region_tag, coord_x, coord_y, coord_z, limit_x, limit_y
    input  logic [175:0] s_axis_tdata,
    // op
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // match_index, out_x, out_y, out_z
    output logic [87:0]  m_axis_tdata,
    // found
    output logic         m_axis_tuser
);

    cmd_t               cmd;
    sts_t               sts;
    logic [INDEX_W-1:0] match_index;
    logic [COORD_W-1:0] res_x;
    logic [COORD_W-1:0] res_y;
    logic [Z_W-1:0]     res_z;

    rwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rwl_dpath #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_op           (s_axis_tuser),
        .in_entry_index  (s_axis_tdata[7:0]),
        .in_region_tag   (s_axis_tdata[15:8]),
        .in_coord_x      (s_axis_tdata[47:16]),
        .in_coord_y      (s_axis_tdata[79:48]),
        .in_coord_z      (s_axis_tdata[111:80]),
        .in_limit_x      (s_axis_tdata[143:112]),
        .in_limit_y      (s_axis_tdata[175:144]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_found       (m_axis_tuser),
        .out_match_index (match_index),
        .out_x           (res_x),
        .out_y           (res_y),
        .out_z           (res_z)
    );

    assign m_axis_tdata = {res_z, res_y, res_x, match_index};

endmodule
